// ===== sv/sbhd_pkg.sv =====
// Shared types, constants and helper functions for the hedge-delay estimator.
package sbhd_pkg;

  localparam int NUM_BUCKETS     = 15;
  localparam int MAX_SAMPLES_DEF = 64;
  localparam int BKT_W           = 4;
  localparam int DIV_STEPS       = 4;    // reciprocal, remainder, fraction products, combine
  localparam int DIV_CNT_W       = 3;
  localparam int PCT             = 99;
  localparam int DIVISOR         = 100;

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP_100         = 32'h51EB_851F;
  localparam int          RECIP_SHIFT       = 37;
  // y / 100 == (y * RECIP_100_SMALL) >> RECIP_SHIFT_SMALL for y below 99*99+1
  localparam logic [12:0] RECIP_100_SMALL   = 13'd5243;
  localparam int          RECIP_SHIFT_SMALL = 19;

  localparam logic [6:0]  MIN_SAMPLES_RST = 7'd10;
  localparam logic [15:0] GAIN_Q8_RST     = 16'd256;
  localparam logic [31:0] FLOOR_RST       = 32'd0;

  localparam logic [1:0] REG_MIN_SAMPLES = 2'd0;
  localparam logic [1:0] REG_GAIN_Q8     = 2'd1;
  localparam logic [1:0] REG_FLOOR_DELAY = 2'd2;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [39:0] KIB = 40'd1024;
  localparam logic [39:0] MIB = 40'd1048576;

  localparam logic [39:0] BUCKET_LIMIT [NUM_BUCKETS-1] = '{
    8 * KIB, 64 * KIB, 128 * KIB, 256 * KIB, 512 * KIB,
    1 * MIB, 2 * MIB, 8 * MIB, 16 * MIB, 32 * MIB,
    64 * MIB, 128 * MIB, 256 * MIB, 512 * MIB
  };

  typedef struct packed {
    logic        op;
    logic [39:0] size_bytes;
    logic [31:0] latency_ms;
  } in_t;

  typedef struct packed {
    logic [31:0] delay_ms;
    logic        used_fallback;
  } out_t;

  typedef struct packed {
    logic accept;
    logic rec_write;
    logic fallback;
    logic div_load_t;
    logic div_load_p;
    logic div_step;
    logic take_t;
    logic ld_i;
    logic get_i;
    logic scan;
    logic add;
    logic gain;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_rec;
    logic need_fb;
    logic div_done;
    logic scan_last;
    logic i_last;
    logic out_free;
  } sts_t;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [39:0] size);
    logic [BKT_W-1:0] b;
    b = BKT_W'(NUM_BUCKETS - 1);
    for (int k = NUM_BUCKETS - 2; k >= 0; k--) begin
      if (size < BUCKET_LIMIT[k]) b = BKT_W'(k);
    end
    return b;
  endfunction

  function automatic logic [31:0] fallback_of(input logic [39:0] size);
    logic [31:0] f;
    if (size < MIB) f = 32'd100;
    else if (size < 8 * MIB) f = 32'd500;
    else if (size < 64 * MIB) f = 32'd1500;
    else if (size < 256 * MIB) f = 32'd3000;
    else f = 32'd5000;
    return f;
  endfunction

endpackage

// ===== sv/sbhd_ctrl.sv =====
// Sequencer for record, fallback and rank-select percentile queries.
module sbhd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sbhd_pkg::sts_t sts,
  output sbhd_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_REC, S_DIVT, S_LDI, S_GETI, S_SCAN,
    S_MUL, S_DIVP, S_ADD, S_GAIN, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_rec) begin
          state_nxt = S_REC;
        end else if (sts.need_fb) begin
          cmd.fallback = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.div_load_t = 1'b1;
          state_nxt      = S_DIVT;
        end
      end
      S_REC: begin
        cmd.rec_write = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_DIVT: begin
        if (sts.div_done) begin
          cmd.take_t = 1'b1;
          state_nxt  = S_LDI;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_LDI: begin
        cmd.ld_i  = 1'b1;
        state_nxt = S_GETI;
      end
      S_GETI: begin
        cmd.get_i = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = sts.i_last ? S_MUL : S_LDI;
      end
      S_MUL: begin
        cmd.div_load_p = 1'b1;
        state_nxt      = S_DIVP;
      end
      S_DIVP: begin
        if (sts.div_done) state_nxt = S_ADD;
        else cmd.div_step = 1'b1;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    in_stall_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

`ifndef NO_ASSERTIONS
  a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (state_r != S_IDLE)) else $error("stall out of step with state");
  a_rec_return: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rec_write |=> state_r == S_IDLE) else $error("record did not finish");
  a_one_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !cmd.accept) else $error("back-to-back accept");
`endif

endmodule

// ===== sv/sbhd_dp.sv =====
// Datapath: sample store, bucket counters, divider, rank select and scaling.
module sbhd_dp #(
  parameter int MAX_SAMPLES = sbhd_pkg::MAX_SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sbhd_pkg::in_t  in_data,
  output sbhd_pkg::out_t out_data,
  output logic           out_valid,
  input  logic           out_stall,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  sbhd_pkg::cmd_t cmd,
  output sbhd_pkg::sts_t sts
);

  localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int BW = sbhd_pkg::BKT_W;
  localparam int AW = BW + SW;
  localparam int DCW = sbhd_pkg::DIV_CNT_W;

  localparam logic [DCW-1:0] ST_RECIP = DCW'(sbhd_pkg::DIV_STEPS);
  localparam logic [DCW-1:0] ST_REM   = DCW'(sbhd_pkg::DIV_STEPS - 1);
  localparam logic [DCW-1:0] ST_FRAC  = DCW'(sbhd_pkg::DIV_STEPS - 2);

  // configuration
  logic [6:0]  min_samples_r;
  logic [15:0] gain_q8_r;
  logic [31:0] floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_samples_r <= sbhd_pkg::MIN_SAMPLES_RST;
      gain_q8_r     <= sbhd_pkg::GAIN_Q8_RST;
      floor_r       <= sbhd_pkg::FLOOR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sbhd_pkg::REG_MIN_SAMPLES: min_samples_r <= cfg_data[6:0];
        sbhd_pkg::REG_GAIN_Q8:     gain_q8_r     <= cfg_data[15:0];
        sbhd_pkg::REG_FLOOR_DELAY: floor_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // item registers
  logic          op_r;
  logic [39:0]   size_r;
  logic [31:0]   lat_r;
  logic [BW-1:0] bucket_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_data.op;
      size_r   <= in_data.size_bytes;
      lat_r    <= in_data.latency_ms;
      bucket_r <= sbhd_pkg::bucket_of(in_data.size_bytes);
    end
  end

  // per-bucket fill count and ring pointer
  logic [CW-1:0] cnt_r  [sbhd_pkg::NUM_BUCKETS];
  logic [SW-1:0] slot_r [sbhd_pkg::NUM_BUCKETS];
  logic [CW-1:0] n_w, nm1_w;
  logic [SW-1:0] slot_w;

  assign n_w    = cnt_r[bucket_r];
  assign nm1_w  = n_w - CW'(1);
  assign slot_w = slot_r[bucket_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < sbhd_pkg::NUM_BUCKETS; b++) begin
        cnt_r[b]  <= '0;
        slot_r[b] <= '0;
      end
    end else if (cmd.rec_write) begin
      if (32'(n_w) < MAX_SAMPLES) cnt_r[bucket_r] <= n_w + CW'(1);
      slot_r[bucket_r] <= (slot_w == SW'(MAX_SAMPLES - 1)) ? '0 : slot_w + SW'(1);
    end
  end

  // sample store
  logic [31:0]   mem [2**AW];
  logic [31:0]   rd_data_r;
  logic [SW-1:0] i_r, j_r, c_r, rank_r;
  logic [AW-1:0] rd_addr;

  assign rd_addr = {bucket_r, (cmd.ld_i ? i_r : j_r)};

  always_ff @(posedge clk) begin
    if (cmd.rec_write) mem[{bucket_r, slot_w}] <= lat_r;
    rd_data_r <= mem[rd_addr];
  end

  // shared divide by 100: reciprocal multiply, remainder, then scale the fraction
  logic [DCW-1:0] div_cnt_r;
  logic           div_p_r;
  logic [31:0]    div_x_r;
  logic [31:0]    rq_r;
  logic [6:0]     rr_r;
  logic [38:0]    pa_r;
  logic [13:0]    pb_r;
  logic [31:0]    div_q_r;
  logic [6:0]     div_rem_r;
  logic [63:0]    recip_w;
  logic [31:0]    rr_w;
  logic [26:0]    pb_scaled_w;
  logic [31:0]    t_w;
  logic [31:0]    vlo_r, vhi_r, vi_r;
  logic [6:0]     frac_r;

  assign t_w         = 32'(sbhd_pkg::PCT) * 32'(nm1_w);
  assign recip_w     = 64'(div_x_r) * 64'(sbhd_pkg::RECIP_100);
  assign rr_w        = div_x_r - rq_r * 32'(sbhd_pkg::DIVISOR);
  assign pb_scaled_w = 27'(pb_r) * 27'(sbhd_pkg::RECIP_100_SMALL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_load_t || cmd.div_load_p) begin
      div_cnt_r <= ST_RECIP;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load_t || cmd.div_load_p) begin
      div_x_r <= cmd.div_load_t ? t_w : (vhi_r - vlo_r);
      div_p_r <= cmd.div_load_p;
    end else if (cmd.div_step) begin
      case (div_cnt_r)
        ST_RECIP: rq_r <= 32'(recip_w[63:sbhd_pkg::RECIP_SHIFT]);
        ST_REM:   rr_r <= rr_w[6:0];
        ST_FRAC: begin
          pa_r <= 39'(rq_r) * 39'(frac_r);
          pb_r <= 14'(rr_r) * 14'(frac_r);
        end
        default: begin
          // diff*r/100 = (diff/100)*r + ((diff%100)*r)/100
          div_q_r   <= div_p_r ?
                       32'(pa_r + 39'(pb_scaled_w[26:sbhd_pkg::RECIP_SHIFT_SMALL])) : rq_r;
          div_rem_r <= rr_r;
        end
      endcase
    end
  end

  // rank select: value of rank lo and rank hi among the bucket's samples
  logic [SW-1:0] lo_r, hi_r;
  logic [SW:0]   hi_w;
  logic          less_w;
  logic [SW-1:0] rank_nxt;

  assign hi_w     = {1'b0, div_q_r[SW-1:0]} + (SW+1)'(div_rem_r != 7'd0);
  assign less_w   = (rd_data_r < vi_r) || ((rd_data_r == vi_r) && (c_r < i_r));
  assign rank_nxt = rank_r + SW'(less_w);

  always_ff @(posedge clk) begin
    if (cmd.take_t) begin
      lo_r   <= div_q_r[SW-1:0];
      frac_r <= div_rem_r;
      hi_r   <= (hi_w > (SW+1)'(nm1_w)) ? SW'(nm1_w) : hi_w[SW-1:0];
      i_r    <= '0;
    end
    if (cmd.ld_i) j_r <= '0;
    if (cmd.get_i) begin
      vi_r   <= rd_data_r;
      j_r    <= j_r + SW'(1);
      c_r    <= '0;
      rank_r <= '0;
    end
    if (cmd.scan) begin
      j_r    <= j_r + SW'(1);
      c_r    <= c_r + SW'(1);
      rank_r <= rank_nxt;
      if (sts.scan_last) begin
        if (rank_nxt == lo_r) vlo_r <= vi_r;
        if (rank_nxt == hi_r) vhi_r <= vi_r;
        i_r <= i_r + SW'(1);
      end
    end
  end

  // interpolate, scale, saturate and floor
  logic [32:0] p99_r;
  logic [48:0] scaled_w;
  logic [40:0] target_w;
  logic [31:0] sat_w, fb_w;
  logic [31:0] res_r;
  logic        res_fb_r;

  assign scaled_w = p99_r * 49'(gain_q8_r);
  assign target_w = scaled_w[48:8];
  assign sat_w    = (target_w[40:32] != '0) ? 32'hFFFF_FFFF : target_w[31:0];
  assign fb_w     = sbhd_pkg::fallback_of(size_r);

  always_ff @(posedge clk) begin
    if (cmd.add) p99_r <= {1'b0, vlo_r} + {1'b0, div_q_r};
    if (cmd.gain) begin
      res_r    <= (sat_w > floor_r) ? sat_w : floor_r;
      res_fb_r <= 1'b0;
    end
    if (cmd.fallback) begin
      res_r    <= (fb_w > floor_r) ? fb_w : floor_r;
      res_fb_r <= 1'b1;
    end
  end

  // output register
  logic           out_valid_r;
  sbhd_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.delay_ms      <= res_r;
      out_data_r.used_fallback <= res_fb_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic [6:0] need_w;
  assign need_w = (min_samples_r == 7'd0) ? 7'd1 : min_samples_r;

  assign sts.is_rec    = (op_r == sbhd_pkg::OP_RECORD);
  assign sts.need_fb   = (32'(n_w) < 32'(need_w));
  assign sts.div_done  = (div_cnt_r == '0);
  assign sts.scan_last = (CW'(c_r) == nm1_w);
  assign sts.i_last    = (CW'(i_r) == nm1_w);
  assign sts.out_free  = !out_valid_r || !out_stall;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(n_w) <= MAX_SAMPLES) else $error("bucket count overflow");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r) else $error("result not presented");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(div_cnt_r) <= sbhd_pkg::DIV_STEPS) else $error("divider count out of range");
  a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (lo_r <= hi_r) && (CW'(hi_r) <= nm1_w)) else $error("bad ranks");
`endif

endmodule

// ===== sv/size_bucketed_p99_hedge_delay.sv =====
// Top level of the size-bucketed p99 hedge-delay estimator.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | sbhd_pkg::in_t
//  out_    | output    | out_valid / out_stall| sbhd_pkg::out_t
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A record passes through accept, decode and store write.
// A query below the sample minimum passes through accept, decode and
// output load, which waits for a free output. In a full query, one
// comparator ranks every sample against all others over the single read port.
// Reset is synchronous, active low; sample memory is not cleared.
// Input stalls whenever a transaction is in progress; a pending result
// waits in the output register and holds a finished query until taken.
module size_bucketed_p99_hedge_delay #(
  parameter int MAX_SAMPLES = sbhd_pkg::MAX_SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sbhd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sbhd_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  sbhd_pkg::cmd_t cmd;
  sbhd_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  sbhd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbhd_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
